// ===== src/cpnp_pkg.sv =====
// Package for the collider pair narrow-phase block: constants, state codes,
// command and status structs shared by controller, datapath and top level.
`timescale 1ns / 1ps

package cpnp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NORM_ONE      = 65536;
    localparam int NORM_W        = 18;
    localparam int CW            = 32;
    localparam int EW            = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       prep;
        logic       sq;
        logic [1:0] sq_idx;
        logic       sqrt_start;
        logic       sqrt_step;
        logic       div_start;
        logic       div_step;
        logic [1:0] div_idx;
        logic       fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_dist;
        logic sqrt_done;
        logic div_done;
        logic need_div;
    } t_stat;

endpackage

// ===== src/cpnp_if.sv =====
// Valid/ready channel interface carrying one payload struct or vector.
// Depends on nothing.
`timescale 1ns / 1ps

interface cpnp_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cpnp_ctrl.sv =====
// Controller state machine for the narrow-phase test.
// Depends on cpnp_pkg.
`timescale 1ns / 1ps

module cpnp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic            i_out_ready,
    input  cpnp_pkg::t_stat i_stat,
    output cpnp_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_out_valid
);
    import cpnp_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_busy      = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_go) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_idx      = '0;
                n_state    = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.sq     = 1'b1;
                o_cmd.sq_idx = r_idx;
                if (r_idx == 2'd2) begin
                    n_state = i_stat.need_dist ? ST_SQRT : ST_FIN;
                    o_cmd.sqrt_start = i_stat.need_dist;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_done) begin
                    n_idx = '0;
                    if (i_stat.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_idx  = r_idx;
                if (i_stat.div_done) begin
                    if (r_idx == 2'd2) begin
                        n_state = ST_FIN;
                    end else begin
                        n_idx           = r_idx + 2'd1;
                        o_cmd.div_start = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                // The result register frees up at the edge where the sink takes it.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_div_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_idx != 2'd3)
        else $error("divide index out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped");
    a_idle_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_go) |=> r_state == ST_PREP)
        else $error("test not started");
endmodule

// ===== src/cpnp_dp.sv =====
// Datapath: held collider, clamp and overlap logic, squared distance,
// shared bit-serial square root and divider. Depends on cpnp_pkg.
`timescale 1ns / 1ps

module cpnp_dp #(
    parameter int FRAC_BITS = cpnp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_hold,
    input  logic                                 i_kind,
    input  logic signed [cpnp_pkg::CW-1:0]       i_cx, i_cy, i_cz,
    input  logic        [cpnp_pkg::EW-1:0]       i_ex, i_ey, i_ez,
    input  logic                                 i_rst_n,
    input  cpnp_pkg::t_cmd                       i_cmd,
    output cpnp_pkg::t_stat                      o_stat,
    output logic                                 o_hit,
    output logic signed [cpnp_pkg::NORM_W-1:0]   o_nx, o_ny, o_nz,
    output logic signed [cpnp_pkg::CW-1:0]       o_depth,
    output logic signed [cpnp_pkg::CW-1:0]       o_px, o_py, o_pz
);
    import cpnp_pkg::*;

    localparam logic [33:0] NEAR_EPS = 34'((64'd1 << FRAC_BITS) / 10000);

    // Held collider.
    logic              r_hk;
    logic signed [33:0] r_hc [3];
    logic signed [33:0] r_he [3];
    // Current (second) collider.
    logic              r_k;
    logic signed [33:0] r_c [3];
    logic signed [33:0] r_e [3];
    // Working set: role A (box or first sphere), role B.
    logic [1:0]        r_mode; // 0 box-box, 1 sphere-sphere, 2 box-sphere
    logic signed [35:0] r_d [3];   // difference vector
    logic signed [35:0] r_cp [3];  // closest point / contact base
    logic signed [35:0] r_l [3];   // sphere center minus box center
    logic signed [35:0] r_ov [3];
    logic signed [35:0] r_ra, r_rad;
    logic [65:0]       r_acc;
    logic              r_miss;
    logic [65:0]       r_sq_x, r_sq_res, r_sq_bit;
    logic [33:0]       r_dist;
    logic [66:0]       r_rem;
    logic [66:0]       r_dvd;
    logic [17:0]       r_q;
    logic [4:0]        r_dcnt;
    logic signed [NORM_W-1:0] r_n [3];
    logic signed [NORM_W-1:0] r_on [3];
    logic              r_hit;
    logic signed [35:0] r_depth;
    logic signed [35:0] r_p [3];

    integer i;

    // Held and current item capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hk <= 1'b0;
            for (i = 0; i < 3; i++) begin
                r_hc[i] <= '0;
                r_he[i] <= '0;
            end
        end else if (i_hold) begin
            r_hk    <= i_kind;
            r_hc[0] <= 34'(i_cx); r_hc[1] <= 34'(i_cy); r_hc[2] <= 34'(i_cz);
            r_he[0] <= 34'({1'b0, i_ex}); r_he[1] <= 34'({1'b0, i_ey});
            r_he[2] <= 34'({1'b0, i_ez});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k    <= i_kind;
            r_c[0] <= 34'(i_cx); r_c[1] <= 34'(i_cy); r_c[2] <= 34'(i_cz);
            r_e[0] <= 34'({1'b0, i_ex}); r_e[1] <= 34'({1'b0, i_ey});
            r_e[2] <= 34'({1'b0, i_ez});
        end
    end

    function automatic logic signed [35:0] abs36(input logic signed [35:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Preparation: roles, differences, clamping, overlaps.
    logic signed [35:0] bc [3], bh [3], sc [3], pa [3];
    logic signed [35:0] pre_d [3], pre_cp [3], pre_l [3], pre_ov [3];
    logic signed [35:0] lo, hi, v;
    logic [1:0]         pre_mode;
    logic signed [35:0] pre_ra, pre_rad;
    always_comb begin
        pre_mode = (!r_hk && !r_k) ? 2'd0 : ((r_hk && r_k) ? 2'd1 : 2'd2);
        for (int j = 0; j < 3; j++) begin
            if (r_hk && !r_k) begin
                bc[j] = 36'(r_c[j]);  bh[j] = 36'(r_e[j]);  sc[j] = 36'(r_hc[j]);
            end else begin
                bc[j] = 36'(r_hc[j]); bh[j] = 36'(r_he[j]); sc[j] = 36'(r_c[j]);
            end
            pa[j] = 36'(r_hc[j]);
        end
        pre_rad = (r_hk && !r_k) ? 36'(r_he[0]) : 36'(r_e[0]);
        pre_ra  = (pre_mode == 2'd1) ? 36'(r_he[0]) + 36'(r_e[0]) : pre_rad;
        for (int j = 0; j < 3; j++) begin
            lo = bc[j] - bh[j];
            hi = bc[j] + bh[j];
            v  = sc[j];
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            pre_l[j]  = sc[j] - bc[j];
            pre_ov[j] = 36'(r_he[j]) + 36'(r_e[j]) - abs36(36'(r_c[j]) - 36'(r_hc[j]));
            if (pre_mode == 2'd2) begin
                pre_cp[j] = v;
                pre_d[j]  = sc[j] - v;
            end else begin
                pre_cp[j] = pa[j];
                pre_d[j]  = 36'(r_c[j]) - 36'(r_hc[j]);
            end
        end
    end

    // Squared distance, one component a cycle, with early-miss checks.
    logic [35:0] sq_a;
    logic [71:0] sq_s;
    logic [71:0] r2;
    always_comb begin
        sq_a = 36'(abs36(r_d[i_cmd.sq_idx]));
        sq_s = 72'(sq_a[33:0]) * 72'(sq_a[33:0]);
        r2   = 72'(r_ra[33:0]) * 72'(r_ra[33:0]);
    end

    logic need_div;
    assign need_div = (r_mode == 2'd1) ? (r_dist != 0) : (r_dist > NEAR_EPS);

    always_comb begin
        o_stat.need_dist = (r_mode != 2'd0) && !r_miss && !(i_cmd.sq &&
            (r_ra <= 0 || 36'(sq_a) >= r_ra || sq_s >= r2 - 72'(r_acc)));
        o_stat.sqrt_done = (r_sq_bit == 0);
        o_stat.div_done  = (r_dcnt == 0);
        o_stat.need_div  = need_div;
    end

    // Divider quotient rounding: (2*a*65536 + dist) / (2*dist).
    logic [66:0] div_num;
    always_comb div_num = (67'(abs36(r_d[i_cmd.div_idx + (i_cmd.div_step ? 2'd1 : 2'd0)]))
                          << 17) + 67'(r_dist);

    logic [67:0] trial;
    always_comb trial = {r_rem[66:0], r_dvd[66]} - {33'd0, r_dist, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_mode <= pre_mode;
            r_ra   <= pre_ra;
            r_rad  <= pre_rad;
            r_acc  <= '0;
            r_miss <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                r_d[j] <= pre_d[j]; r_cp[j] <= pre_cp[j];
                r_l[j] <= pre_l[j]; r_ov[j] <= pre_ov[j];
            end
        end
        if (i_cmd.sq) begin
            if (r_ra <= 0 || 36'(sq_a) >= r_ra || sq_s >= r2 - 72'(r_acc))
                r_miss <= 1'b1;
            else
                r_acc <= r_acc + 66'(sq_s);
        end
        if (i_cmd.sqrt_start) begin
            r_sq_x   <= r_acc + 66'(sq_s);
            r_sq_res <= '0;
            r_sq_bit <= 66'd1 << 64;
            r_dist   <= '0;
        end else if (i_cmd.sqrt_step && r_sq_bit != 0) begin
            if (r_sq_x >= r_sq_res + r_sq_bit) begin
                r_sq_x   <= r_sq_x - (r_sq_res + r_sq_bit);
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                if ((r_sq_bit >> 2) == 0) r_dist <= 34'(((r_sq_res >> 1) + r_sq_bit));
            end else begin
                r_sq_res <= r_sq_res >> 1;
                if ((r_sq_bit >> 2) == 0) r_dist <= 34'(r_sq_res >> 1);
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_cmd.div_start) begin
            // The quotient fits 18 bits, so all but the low 18 dividend bits
            // start out in the remainder.
            r_dvd  <= div_num << 49;
            r_rem  <= div_num >> 18;
            r_q    <= '0;
            r_dcnt <= 5'd18;
        end else if (i_cmd.div_step && r_dcnt != 0) begin
            if (!trial[67]) begin
                r_rem <= trial[66:0];
                r_q   <= {r_q[16:0], 1'b1};
            end else begin
                r_rem <= {r_rem[65:0], r_dvd[66]};
                r_q   <= {r_q[16:0], 1'b0};
            end
            r_dvd  <= r_dvd << 1;
            r_dcnt <= r_dcnt - 5'd1;
        end
    end

    // Write quotients into normal lanes when each division completes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            for (int j = 0; j < 3; j++) r_n[j] <= '0;
        end else if (i_cmd.div_step && r_dcnt == 0) begin
            r_n[i_cmd.div_idx] <= r_d[i_cmd.div_idx] < 0 ? -$signed(r_q) : $signed(r_q);
        end
    end

    // Final result assembly.
    logic [1:0] bax, dax;
    logic signed [35:0] al [3];
    logic signed [NORM_W-1:0] fn [3];
    logic signed [71:0] prod;
    logic signed [35:0] fp [3];
    logic signed [35:0] fdep;
    logic               fhit;
    always_comb begin
        for (int j = 0; j < 3; j++) al[j] = abs36(r_l[j]);
        if (r_ov[0] <= r_ov[1] && r_ov[0] <= r_ov[2]) bax = 2'd0;
        else if (r_ov[1] <= r_ov[2]) bax = 2'd1;
        else bax = 2'd2;
        if (al[0] > al[1] && al[0] > al[2]) dax = 2'd0;
        else if (al[1] > al[0] && al[1] > al[2]) dax = 2'd1;
        else dax = 2'd2;
        for (int j = 0; j < 3; j++) begin
            fn[j] = r_n[j];
            fp[j] = r_cp[j];
        end
        fhit = 1'b0;
        fdep = '0;
        prod = '0;
        unique case (r_mode)
            2'd0: begin
                fhit = !(r_ov[0] < 0 || r_ov[1] < 0 || r_ov[2] < 0);
                for (int j = 0; j < 3; j++) begin
                    fn[j] = '0;
                    fp[j] = (36'(r_hc[j]) + 36'(r_c[j])) >>> 1;
                end
                fn[bax] = r_d[bax] > 0 ? 18'sd65536 : -18'sd65536;
                fdep = r_ov[bax];
            end
            2'd1: begin
                fhit = !r_miss;
                if (r_dist == 0) begin
                    for (int j = 0; j < 3; j++) fn[j] = '0;
                    fn[0] = 18'sd65536;
                end
                fdep = r_ra - 36'(r_dist);
                for (int j = 0; j < 3; j++) begin
                    prod  = 72'(fn[j]) * 72'(r_he[0]);
                    fp[j] = r_cp[j] + 36'(prod >>> 16);
                end
            end
            default: begin
                fhit = !r_miss;
                if (!need_div) begin
                    for (int j = 0; j < 3; j++) fn[j] = '0;
                    fn[dax] = r_l[dax] > 0 ? 18'sd65536 :
                              (r_l[dax] < 0 ? -18'sd65536 : 18'sd0);
                end
                fdep = r_rad - 36'(r_dist);
            end
        endcase
    end

    function automatic logic signed [35:0] sat(input logic signed [35:0] x);
        if (x > 36'sh07FFFFFFF) return 36'sh07FFFFFFF;
        if (x < -36'sh080000000) return -36'sh080000000;
        return x;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_hit   <= fhit;
            r_depth <= fhit ? sat(fdep) : '0;
            for (int j = 0; j < 3; j++) begin
                r_p[j]  <= fhit ? sat(fp[j]) : '0;
                r_on[j] <= fhit ? fn[j] : '0;
            end
        end
    end

    assign o_hit   = r_hit;
    assign o_nx    = r_on[0];
    assign o_ny    = r_on[1];
    assign o_nz    = r_on[2];
    assign o_depth = r_depth[31:0];
    assign o_px    = r_p[0][31:0];
    assign o_py    = r_p[1][31:0];
    assign o_pz    = r_p[2][31:0];

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_start |=> r_sq_bit != 0)
        else $error("square root did not start");
    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dcnt == 5'd18)
        else $error("divider did not start");
    a_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.fin) && !r_hit |-> r_depth == 0)
        else $error("depth set without hit");
endmodule

// ===== src/collider_pair_narrow_phase.sv =====
// Collider pair narrow phase: one held collider, one test per request with the pair-last flag set.
// A request with the pair-last flag clear is captured as the held collider. A test ends
// after preparation and the squared-distance steps, after the 33-step square root too,
// or after three 18-step divisions as well; the next request is taken once it is idle.
// A waiting result stalls only a following test, in its final state.
// Reset is synchronous, active low, and clears the held collider to a zero box.
`timescale 1ns / 1ps

module collider_pair_narrow_phase #(
    parameter int FRAC_BITS = cpnp_pkg::FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpnp_if.sink   i_req,
    cpnp_if.source o_res
);
    import cpnp_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy, go, hold;
    logic  hit;
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic signed [CW-1:0] dep, px, py, pz;

    // Request layout: kind, pair_last, cx, cy, cz, ex, ey, ez (msb first).
    logic       req_kind, req_last;
    assign req_kind = i_req.data[190];
    assign req_last = i_req.data[189];

    assign i_req.ready = !busy;
    assign go   = i_req.valid && !busy && req_last;
    assign hold = i_req.valid && !busy && !req_last;

    cpnp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_out_ready(o_res.ready),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy), .o_out_valid(o_res.valid)
    );

    cpnp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_hold(hold), .i_kind(req_kind),
        .i_cx(i_req.data[188:157]), .i_cy(i_req.data[156:125]),
        .i_cz(i_req.data[124:93]), .i_ex(i_req.data[92:62]),
        .i_ey(i_req.data[61:31]), .i_ez(i_req.data[30:0]),
        .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat), .o_hit(hit),
        .o_nx(nx), .o_ny(ny), .o_nz(nz), .o_depth(dep),
        .o_px(px), .o_py(py), .o_pz(pz)
    );

    assign o_res.data = {hit, nx, ny, nz, dep, px, py, pz};
endmodule

// ===== test/tb.sv =====
// Testbench for collider_pair_narrow_phase: random and directed collider pairs
// are checked against a behavioral contact predictor. Depends on cpnp_pkg,
// cpnp_if and the top-level RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic              kind;
    logic              pair_last;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]       ex;
    logic [30:0]       ey;
    logic [30:0]       ez;
} t_collider;

typedef struct packed {
    logic              hit;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic signed [31:0] depth;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
} t_contact;

class contact_scoreboard;
    localparam longint NEAR_EPS = (64'sd1 <<< cpnp_pkg::FRAC_BITS_DEF) / 10000;

    logic     held_kind;
    longint   held_c[3];
    longint   held_e[3];
    t_contact pending_contacts[$];
    int       n_errors;
    int       n_tests;
    int       n_hits;

    function new();
        held_kind = 0;
        foreach (held_c[i]) begin
            held_c[i] = 0;
            held_e[i] = 0;
        end
        n_errors = 0;
        n_tests  = 0;
        n_hits   = 0;
    endfunction

    function longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function longint floor_div(longint v, longint d);
        longint q;
        q = v / d;
        if (v % d != 0 && v < 0) q--;
        return q;
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint floor_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // Squared length of d when strictly below r*r, computed without overflow.
    function bit within_radius(longint d[3], longint r, output longint unsigned d2);
        longint unsigned r2, acc, a, s;
        d2 = 0;
        if (r <= 0) return 0;
        r2 = longint'(r) * longint'(r);
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            a = mag(d[i]);
            if (a >= r) return 0;
            s = a * a;
            if (s >= r2 - acc) return 0;
            acc += s;
        end
        d2 = acc;
        return 1;
    endfunction

    function void unit_vec(longint d[3], longint dlen, ref longint n[3]);
        longint m;
        for (int i = 0; i < 3; i++) begin
            m = (mag(d[i]) * 2 * 65536 + dlen) / (2 * dlen);
            n[i] = d[i] < 0 ? -m : m;
        end
    endfunction

    function void box_sphere(longint bc[3], longint bh[3], longint sc[3], longint rad,
                             ref bit hit, ref longint n[3], ref longint dep,
                             ref longint p[3]);
        longint cp[3], d[3], l[3], a[3], lo, hi, v, dlen;
        longint unsigned d2;
        int ax;
        for (int i = 0; i < 3; i++) begin
            lo = bc[i] - bh[i];
            hi = bc[i] + bh[i];
            v = sc[i];
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            cp[i] = v;
            d[i] = sc[i] - v;
        end
        if (!within_radius(d, rad, d2)) return;
        dlen = floor_sqrt(d2);
        hit = 1;
        if (dlen > NEAR_EPS) begin
            unit_vec(d, dlen, n);
        end else begin
            // Center on or inside the box: push out along the dominant axis.
            for (int i = 0; i < 3; i++) begin
                l[i] = sc[i] - bc[i];
                a[i] = mag(l[i]);
            end
            if (a[0] > a[1] && a[0] > a[2]) ax = 0;
            else if (a[1] > a[0] && a[1] > a[2]) ax = 1;
            else ax = 2;
            n[ax] = l[ax] > 0 ? 65536 : (l[ax] < 0 ? -65536 : 0);
        end
        dep = rad - dlen;
        for (int i = 0; i < 3; i++) p[i] = cp[i];
    endfunction

    function void note_request(t_collider r);
        longint c[3], e[3], d[3], ov[3], n[3], p[3], dep, dlen;
        longint unsigned d2;
        bit hit;
        int ax;
        t_contact x;
        c[0] = r.cx; c[1] = r.cy; c[2] = r.cz;
        e[0] = r.ex; e[1] = r.ey; e[2] = r.ez;
        if (!r.pair_last) begin
            held_kind = r.kind;
            held_c = c;
            held_e = e;
            return;
        end
        hit = 0;
        dep = 0;
        foreach (n[i]) begin
            n[i] = 0;
            p[i] = 0;
        end
        if (held_kind == 0 && r.kind == 0) begin
            hit = 1;
            for (int i = 0; i < 3; i++) begin
                d[i] = c[i] - held_c[i];
                ov[i] = held_e[i] + e[i] - mag(d[i]);
                if (ov[i] < 0) hit = 0;
            end
            if (hit) begin
                if (ov[0] <= ov[1] && ov[0] <= ov[2]) ax = 0;
                else if (ov[1] <= ov[2]) ax = 1;
                else ax = 2;
                n[ax] = d[ax] > 0 ? 65536 : -65536;
                dep = ov[ax];
                for (int i = 0; i < 3; i++) p[i] = floor_div(held_c[i] + c[i], 2);
            end
        end else if (held_kind == 1 && r.kind == 1) begin
            for (int i = 0; i < 3; i++) d[i] = c[i] - held_c[i];
            if (within_radius(d, held_e[0] + e[0], d2)) begin
                dlen = floor_sqrt(d2);
                hit = 1;
                if (dlen == 0) n[0] = 65536;
                else unit_vec(d, dlen, n);
                dep = held_e[0] + e[0] - dlen;
                for (int i = 0; i < 3; i++)
                    p[i] = held_c[i] + floor_div(n[i] * held_e[0], 65536);
            end
        end else if (held_kind == 0) begin
            box_sphere(held_c, held_e, c, e[0], hit, n, dep, p);
        end else begin
            box_sphere(c, e, held_c, held_e[0], hit, n, dep, p);
        end
        x.hit   = hit;
        x.nx    = hit ? n[0][17:0] : '0;
        x.ny    = hit ? n[1][17:0] : '0;
        x.nz    = hit ? n[2][17:0] : '0;
        x.depth = hit ? 32'(clamp32(dep)) : '0;
        x.px    = hit ? 32'(clamp32(p[0])) : '0;
        x.py    = hit ? 32'(clamp32(p[1])) : '0;
        x.pz    = hit ? 32'(clamp32(p[2])) : '0;
        pending_contacts = {pending_contacts, x};
        n_tests++;
        if (hit) n_hits++;
    endfunction

    function void check_contact(t_contact a);
        t_contact x;
        if (pending_contacts.size() == 0) begin
            $error("unexpected contact result %h", a);
            n_errors++;
            return;
        end
        x = pending_contacts.pop_front();
        if (a.hit !== x.hit) begin
            $error("hit: expected %0d, got %0d", x.hit, a.hit); n_errors++;
        end
        if (a.nx !== x.nx) begin
            $error("normal_x: expected %0d, got %0d", x.nx, a.nx); n_errors++;
        end
        if (a.ny !== x.ny) begin
            $error("normal_y: expected %0d, got %0d", x.ny, a.ny); n_errors++;
        end
        if (a.nz !== x.nz) begin
            $error("normal_z: expected %0d, got %0d", x.nz, a.nz); n_errors++;
        end
        if (a.depth !== x.depth) begin
            $error("depth: expected %0d, got %0d", x.depth, a.depth); n_errors++;
        end
        if (a.px !== x.px) begin
            $error("contact_x: expected %0d, got %0d", x.px, a.px); n_errors++;
        end
        if (a.py !== x.py) begin
            $error("contact_y: expected %0d, got %0d", x.py, a.py); n_errors++;
        end
        if (a.pz !== x.pz) begin
            $error("contact_z: expected %0d, got %0d", x.pz, a.pz); n_errors++;
        end
    endfunction
endclass

module tb;
    import cpnp_pkg::*;

    localparam int     ONE       = 65536;
    localparam longint MAX_CYCLE = 3000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    longint cycle = 0;
    int sender_idle_pct = 9;
    int receiver_idle_pct = 68;
    int hold_off = 0;
    int n_sent = 0;

    cpnp_if #(.W($bits(t_collider))) req_ch ();
    cpnp_if #(.W($bits(t_contact)))  res_ch ();

    contact_scoreboard contacts = new();

    collider_pair_narrow_phase u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long hold-off when one is armed.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off = hold_off - 1;
            res_ch.ready = 0;
        end else begin
            res_ch.ready = i_rst_n && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) contacts.check_contact(res_ch.data);
    end

    initial begin
        req_ch.valid = 0;
        req_ch.data  = '0;
        res_ch.ready = 0;
    end

    // Called right after a falling edge; returns right after a falling edge.
    task automatic send_collider(t_collider r);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid = 0;
            @(negedge i_clk);
        end
        req_ch.valid = 1;
        req_ch.data  = r;
        do @(posedge i_clk); while (!req_ch.ready);
        contacts.note_request(r);
        n_sent++;
        @(negedge i_clk);
        req_ch.valid = 0;
    endtask

    function automatic t_collider make(bit kind, bit last, longint x, longint y, longint z,
                                       longint ex, longint ey, longint ez);
        t_collider r;
        r.kind = kind; r.pair_last = last;
        r.cx = 32'(x); r.cy = 32'(y); r.cz = 32'(z);
        r.ex = 31'(ex); r.ey = 31'(ey); r.ez = 31'(ez);
        return r;
    endfunction

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
    endfunction

    function automatic t_collider random_collider(bit last);
        t_collider r;
        int mode;
        mode = $urandom_range(99);
        r.kind = 1'($urandom_range(1));
        r.pair_last = last;
        if (mode < 10) begin
            // Full-range values reach the saturation and no-hit corners.
            r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
            r.ex = 31'($urandom); r.ey = 31'($urandom); r.ez = 31'($urandom);
        end else if (mode < 20) begin
            r.cx = near_coord() >>> 8; r.cy = near_coord() >>> 8; r.cz = near_coord() >>> 8;
            r.ex = 31'($urandom_range(0, 8)); r.ey = 31'($urandom_range(0, 8));
            r.ez = 31'($urandom_range(0, 8));
        end else begin
            r.cx = near_coord(); r.cy = near_coord(); r.cz = near_coord();
            r.ex = 31'($urandom_range(0, 6 * ONE)); r.ey = 31'($urandom_range(0, 6 * ONE));
            r.ez = 31'($urandom_range(0, 6 * ONE));
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (contacts.pending_contacts.size() != 0) @(negedge i_clk);
    endtask

    // A held collider (one time in ten sent as a test instead) followed by one to three
    // tests; sometimes the tests sit right on or close to the held one's center.
    task automatic send_pair_group();
        t_collider h, t;
        int ntests;
        h = random_collider(0);
        if ($urandom_range(9) == 0) h.pair_last = 1;
        send_collider(h);
        ntests = $urandom_range(1, 3);
        repeat (ntests) begin
            t = random_collider(1);
            case ($urandom_range(3))
                0: begin
                    t.cx = h.cx; t.cy = h.cy; t.cz = h.cz;
                end
                1: begin
                    t.cx = h.cx + ($signed($urandom_range(0, 512)) - 256);
                    t.cy = h.cy + ($signed($urandom_range(0, 512)) - 256);
                    t.cz = h.cz + ($signed($urandom_range(0, 512)) - 256);
                end
                default: ;
            endcase
            send_collider(t);
        end
    endtask

    task automatic run_phase(int snd, int rcv, int groups);
        sender_idle_pct = snd;
        receiver_idle_pct = rcv;
        repeat (groups) send_pair_group();
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed items.
        send_collider(make(0, 1, 0, 0, 0, 0, 0, 0));
        send_collider(make(0, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_collider(make(0, 1, ONE, ONE, ONE, ONE, ONE, ONE));
        send_collider(make(0, 1, -ONE, 0, 0, ONE, ONE, ONE));
        send_collider(make(0, 1, 10 * ONE, 0, 0, ONE, ONE, ONE));
        send_collider(make(1, 1, 0, 0, 0, ONE, 0, 0));
        send_collider(make(1, 1, 3 * ONE, ONE, 0, 2 * ONE, 0, 0));
        send_collider(make(1, 1, 0, ONE / 2, 0, ONE, 0, 0));
        send_collider(make(1, 0, 0, 0, 0, 2 * ONE, 0, 0));
        send_collider(make(1, 1, 0, 0, 0, 3 * ONE, 0, 0));
        send_collider(make(1, 1, ONE, 2 * ONE, -2 * ONE, 3 * ONE, 0, 0));
        send_collider(make(0, 1, 3 * ONE, 0, 0, ONE, ONE, ONE));
        send_collider(make(0, 1, 0, 0, 0, 0, 0, 0));
        send_collider(make(1, 1, 100 * ONE, 0, 0, ONE, 0, 0));
        send_collider(make(0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
        send_collider(make(0, 1, -32'sh80000000, -32'sh80000000, -32'sh80000000,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
        send_collider(make(1, 1, 32'h7fffffff, 0, 0, 31'h7fffffff, 0, 0));
        send_collider(make(1, 0, 32'h7fffffff, 0, 0, 31'h7fffffff, 0, 0));
        send_collider(make(1, 1, 32'h7fffff00, 5, 0, 31'h7fffffff, 0, 0));
        send_collider(make(0, 1, 32'h7fffff00, 0, 0, 31'h7fffffff, 3, 3));
        wait_drained();

        run_phase(9, 68, 155);
        run_phase(68, 9, 155);

        // Long receiver stall while requests keep coming.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_off = 400;
        repeat (10) send_pair_group();
        wait_drained();

        run_phase(0, 0, 155);

        repeat (150) @(negedge i_clk);
        $display("sent %0d requests, %0d pair tests, %0d hits", n_sent,
                 contacts.n_tests, contacts.n_hits);
        if (contacts.n_errors == 0 && contacts.pending_contacts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/cpnp_pkg.sv
src/cpnp_if.sv
src/cpnp_ctrl.sv
src/cpnp_dp.sv
src/collider_pair_narrow_phase.sv
test/tb.sv
